@@ rtl/efsa_pkg.sv @@
// Shared types and constants for the earliest-free-server assignment unit.
// Holds the channel payload structs, the sequencer state type and the scan result.
// No dependencies.
`timescale 1ns / 1ps

package efsa_pkg;

	// Sizing of the server table and of the time values.
	localparam int MAX_SERVERS = 64;
	localparam int TIME_BITS   = 32;
	localparam int IDX_W       = $clog2(MAX_SERVERS);
	localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
	localparam int SUM_W       = TIME_BITS + 1;

	// Fixed field widths of the channels.
	localparam int SVC_W  = 16;
	localparam int SRV_W  = 7;
	localparam int OUT_TW = 32;
	localparam int CFG_W  = 7;

	// Largest representable free time, used for saturation.
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef struct packed {
		logic [SVC_W-1:0] service_time;
		logic             first_of_case;
	} efsa_in_t;

	typedef struct packed {
		logic [SRV_W-1:0]  server;
		logic [OUT_TW-1:0] start_time;
		logic [OUT_TW-1:0] finish_time;
		logic [SRV_W-1:0]  next_server;
	} efsa_out_t;

	// Earliest and second earliest entries found by a scan.
	typedef struct packed {
		logic [IDX_W-1:0]     best_idx;
		logic [TIME_BITS-1:0] best_time;
		logic                 second_ok;
		logic [IDX_W-1:0]     second_idx;
		logic [TIME_BITS-1:0] second_time;
	} efsa_scan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} efsa_state_t;

endpackage

@@ rtl/efsa_ram.sv @@
// Free-time memory: one write port and one read port with registered read data.
// Depends on efsa_pkg for depth and width.
`timescale 1ns / 1ps

module efsa_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [efsa_pkg::IDX_W-1:0]     waddr,
	input  logic [efsa_pkg::TIME_BITS-1:0] wdata,
	input  logic                           re,
	input  logic [efsa_pkg::IDX_W-1:0]     raddr,
	output logic [efsa_pkg::TIME_BITS-1:0] rdata
);

	logic [efsa_pkg::TIME_BITS-1:0] mem [efsa_pkg::MAX_SERVERS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/efsa_scan.sv @@
// Streaming scanner that keeps the earliest and second earliest free times.
// Entries arrive in ascending index order, so strict compares give ties to the lower index.
// Depends on efsa_pkg.
`timescale 1ns / 1ps

module efsa_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           valid,
	input  logic [efsa_pkg::IDX_W-1:0]     idx,
	input  logic [efsa_pkg::TIME_BITS-1:0] free_time,
	output efsa_pkg::efsa_scan_t           result
);

	logic                           best_ok_q;
	logic                           second_ok_q;
	logic [efsa_pkg::IDX_W-1:0]     best_idx_q;
	logic [efsa_pkg::IDX_W-1:0]     second_idx_q;
	logic [efsa_pkg::TIME_BITS-1:0] best_time_q;
	logic [efsa_pkg::TIME_BITS-1:0] second_time_q;
	logic                           beats_best;
	logic                           beats_second;

	// Both compares run side by side on the incoming entry.
	assign beats_best   = !best_ok_q || (free_time < best_time_q);
	assign beats_second = !second_ok_q || (free_time < second_time_q);

	// Validity flags restart with every scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_ok_q   <= 1'b0;
			second_ok_q <= 1'b0;
		end else if (start) begin
			best_ok_q   <= 1'b0;
			second_ok_q <= 1'b0;
		end else if (valid) begin
			best_ok_q <= 1'b1;
			if (beats_best) begin
				second_ok_q <= best_ok_q;
			end else if (beats_second) begin
				second_ok_q <= 1'b1;
			end
		end
	end

	// The displaced best entry moves down to second place.
	always_ff @(posedge clk) begin
		if (valid && !start) begin
			if (beats_best) begin
				second_idx_q  <= best_idx_q;
				second_time_q <= best_time_q;
				best_idx_q    <= idx;
				best_time_q   <= free_time;
			end else if (beats_second) begin
				second_idx_q  <= idx;
				second_time_q <= free_time;
			end
		end
	end

	assign result.best_idx    = best_idx_q;
	assign result.best_time   = best_time_q;
	assign result.second_ok   = second_ok_q;
	assign result.second_idx  = second_idx_q;
	assign result.second_time = second_time_q;

endmodule

@@ rtl/earliest_free_server_assign_unit.sv @@
// Top level of the earliest-free-server assignment unit: sequencer, registers and ports.
// Depends on efsa_pkg, efsa_ram and efsa_scan.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    efsa_in_t  (service_time, first_of_case)
// out      output     out_valid/out_stall  efsa_out_t (server, start/finish, next_server)
// cfg      input      cfg_valid/cfg_ready  server_count, 7 bits
//
// A job that takes an unused server while others stay unused skips the scan.
// Any other job scans the first n free times (n = effective server count), one entry per
// cycle through the read port; only a reuse then passes through a write state.
// Reset clears the sequencer, the used-server count and sets server_count to 1;
// the memory is not cleared, since a server is always written before it is searched.
// A stalled output holds its result while the next job is already accepted.
`timescale 1ns / 1ps

module earliest_free_server_assign_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  efsa_pkg::efsa_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output efsa_pkg::efsa_out_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [efsa_pkg::CFG_W-1:0]      cfg_data
);

	efsa_pkg::efsa_state_t state_q;
	efsa_pkg::efsa_state_t state_d;

	logic [efsa_pkg::CFG_W-1:0]     server_count_q;
	logic [efsa_pkg::CNT_W-1:0]     n_eff;
	logic [efsa_pkg::CNT_W-1:0]     used_q;
	logic [efsa_pkg::CNT_W-1:0]     used_eff;
	logic [efsa_pkg::CNT_W-1:0]     used_inc;
	logic                           take_unused;
	logic                           accept;

	logic [efsa_pkg::CNT_W-1:0]     raddr_q;
	logic                           rvld_s1;
	logic [efsa_pkg::IDX_W-1:0]     ridx_s1;
	logic                           mode_pick_q;
	logic                           nxt_cmp_q;
	logic                           scan_done;

	logic [efsa_pkg::SVC_W-1:0]     svc_q;
	logic [efsa_pkg::IDX_W-1:0]     pick_q;
	logic [efsa_pkg::TIME_BITS-1:0] start_q;
	logic [efsa_pkg::TIME_BITS-1:0] finish_q;
	logic [efsa_pkg::IDX_W-1:0]     nxt_q;
	logic [efsa_pkg::IDX_W-1:0]     nxt_idx;
	logic [efsa_pkg::IDX_W-1:0]     cmp_idx;

	logic [efsa_pkg::SUM_W-1:0]     sum;
	logic [efsa_pkg::TIME_BITS-1:0] sat_finish;

	logic                           out_valid_q;
	efsa_pkg::efsa_out_t            out_q;
	logic                           out_load;

	logic                           mem_we;
	logic [efsa_pkg::IDX_W-1:0]     mem_waddr;
	logic [efsa_pkg::TIME_BITS-1:0] mem_wdata;
	logic                           mem_re;
	logic [efsa_pkg::TIME_BITS-1:0] mem_rdata;

	efsa_pkg::efsa_scan_t           scan;

	// Configuration register; writes must arrive only while the unit is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= efsa_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			server_count_q <= cfg_data;
		end
	end

	// Effective server count: zero acts as one, large values clamp to the table size.
	always_comb begin
		if (server_count_q == '0) begin
			n_eff = efsa_pkg::CNT_W'(1);
		end else if (efsa_pkg::CNT_W'(server_count_q) > efsa_pkg::CNT_W'(efsa_pkg::MAX_SERVERS)) begin
			n_eff = efsa_pkg::CNT_W'(efsa_pkg::MAX_SERVERS);
		end else begin
			n_eff = efsa_pkg::CNT_W'(server_count_q);
		end
	end

	// Used-server bookkeeping for the job on the input.
	assign accept      = in_valid && !in_stall;
	assign used_eff    = in_data.first_of_case ? '0 : used_q;
	assign take_unused = used_eff < n_eff;
	assign used_inc    = used_eff + efsa_pkg::CNT_W'(1);

	// Scan ends once every read has been issued and the last data has been seen.
	assign scan_done = (raddr_q == n_eff) && !rvld_s1;

	// Saturating finish time from the earliest server found.
	assign sum        = efsa_pkg::SUM_W'(scan.best_time) + efsa_pkg::SUM_W'(svc_q);
	assign sat_finish = sum[efsa_pkg::TIME_BITS] ? efsa_pkg::TIME_MAX
	                                             : sum[efsa_pkg::TIME_BITS-1:0];

	// Following server after a reuse: the updated server against the runner-up.
	always_comb begin
		if (!scan.second_ok) begin
			cmp_idx = pick_q;
		end else if (finish_q < scan.second_time) begin
			cmp_idx = pick_q;
		end else if (finish_q == scan.second_time) begin
			cmp_idx = (pick_q < scan.second_idx) ? pick_q : scan.second_idx;
		end else begin
			cmp_idx = scan.second_idx;
		end
	end

	assign nxt_idx = nxt_cmp_q ? cmp_idx : nxt_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			efsa_pkg::ST_IDLE: begin
				if (accept) begin
					if (take_unused && (used_inc < n_eff)) begin
						state_d = efsa_pkg::ST_DONE;
					end else begin
						state_d = efsa_pkg::ST_SCAN;
					end
				end
			end
			efsa_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = mode_pick_q ? efsa_pkg::ST_WRITE : efsa_pkg::ST_DONE;
				end
			end
			efsa_pkg::ST_WRITE: begin
				state_d = efsa_pkg::ST_DONE;
			end
			efsa_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = efsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = efsa_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer: handshake, memory ports and result load.
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = scan.best_idx;
		mem_wdata = sat_finish;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			efsa_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				mem_we    = accept && take_unused;
				mem_waddr = used_eff[efsa_pkg::IDX_W-1:0];
				mem_wdata = efsa_pkg::TIME_BITS'(in_data.service_time);
			end
			efsa_pkg::ST_SCAN: begin
				mem_re = raddr_q < n_eff;
			end
			efsa_pkg::ST_WRITE: begin
				mem_we = 1'b1;
			end
			efsa_pkg::ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= efsa_pkg::ST_IDLE;
			used_q      <= '0;
			raddr_q     <= '0;
			rvld_s1     <= 1'b0;
			mode_pick_q <= 1'b0;
			nxt_cmp_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= mem_re;
			if (accept) begin
				used_q      <= take_unused ? used_inc : used_eff;
				raddr_q     <= '0;
				mode_pick_q <= !take_unused;
				nxt_cmp_q   <= !take_unused;
			end else if (mem_re) begin
				raddr_q <= raddr_q + efsa_pkg::CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the job in flight.
	always_ff @(posedge clk) begin
		ridx_s1 <= raddr_q[efsa_pkg::IDX_W-1:0];
		if (accept) begin
			svc_q <= in_data.service_time;
			if (take_unused) begin
				pick_q   <= used_eff[efsa_pkg::IDX_W-1:0];
				start_q  <= '0;
				finish_q <= efsa_pkg::TIME_BITS'(in_data.service_time);
				nxt_q    <= used_inc[efsa_pkg::IDX_W-1:0];
			end
		end
		if ((state_q == efsa_pkg::ST_SCAN) && scan_done && !mode_pick_q) begin
			nxt_q <= scan.best_idx;
		end
		if (state_q == efsa_pkg::ST_WRITE) begin
			pick_q   <= scan.best_idx;
			start_q  <= scan.best_time;
			finish_q <= sat_finish;
		end
		if (out_load) begin
			out_q.server      <= efsa_pkg::SRV_W'(pick_q) + efsa_pkg::SRV_W'(1);
			out_q.start_time  <= efsa_pkg::OUT_TW'(start_q);
			out_q.finish_time <= efsa_pkg::OUT_TW'(finish_q);
			out_q.next_server <= efsa_pkg::SRV_W'(nxt_idx) + efsa_pkg::SRV_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Free-time memory.
	efsa_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (raddr_q[efsa_pkg::IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	// Earliest-entry scanner fed by the read port.
	efsa_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.valid     (rvld_s1),
		.idx       (ridx_s1),
		.free_time (mem_rdata),
		.result    (scan)
	);

endmodule

@@ dv/efsa_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the earliest-free-server assignment unit: keeps its own server table,
// predicts each assignment when a job transfer happens and compares the results in order.
// Depends on efsa_pkg.

module efsa_checker
	import efsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  efsa_in_t          in_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  efsa_out_t         out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	output int unsigned       fail_count,
	output int unsigned       pending
);

	// Shadow copy of the server table and of the server count register.
	logic [TIME_BITS-1:0] free_at [MAX_SERVERS];
	int unsigned          servers_used;
	logic [CFG_W-1:0]     count_reg;

	// Predicted assignments, oldest first.
	efsa_out_t            assign_q [$];
	efsa_out_t            want;

	// Lowest-numbered server with the smallest free time among the first n.
	function automatic int unsigned earliest_server(input int unsigned n);
		int unsigned best;
		int unsigned k;
		best = 0;
		for (k = 1; k < n; k++)
			if (free_at[k] < free_at[best])
				best = k;
		return best;
	endfunction

	// Places one job on the shadow table and returns the result it should produce.
	function automatic efsa_out_t next_assignment(input efsa_in_t job);
		int unsigned          n;
		int unsigned          pick;
		int unsigned          follow;
		logic [TIME_BITS-1:0] start_at;
		logic [TIME_BITS-1:0] done_at;
		logic [TIME_BITS:0]   sum;
		efsa_out_t            res;
		// A count of zero behaves as one server, anything above the table as the full table.
		if (count_reg == 0)
			n = 1;
		else if (count_reg > MAX_SERVERS)
			n = MAX_SERVERS;
		else
			n = count_reg;
		if (job.first_of_case) begin
			foreach (free_at[i])
				free_at[i] = '0;
			servers_used = 0;
		end
		// Unused servers are handed out first, in index order, starting at time zero.
		if (servers_used < n) begin
			pick = servers_used;
			start_at = '0;
			servers_used++;
		end else begin
			pick = earliest_server(n);
			start_at = free_at[pick];
		end
		// The new free time holds at the largest value instead of wrapping.
		sum = {1'b0, start_at} + job.service_time;
		done_at = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
		free_at[pick] = done_at;
		follow = (servers_used < n) ? servers_used : earliest_server(n);
		res.server      = SRV_W'(pick + 1);
		res.start_time  = OUT_TW'(start_at);
		res.finish_time = OUT_TW'(done_at);
		res.next_server = SRV_W'(follow + 1);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [OUT_TW-1:0] exp_val,
			input logic [OUT_TW-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// Watch all three channels; register writes first, then results, then new jobs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (free_at[i])
				free_at[i] = '0;
			servers_used = 0;
			count_reg = 1;
			assign_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_reg = cfg_data;
			// Each result transfer is matched against the oldest prediction.
			if (out_valid && !out_stall) begin
				if (assign_q.size() == 0) begin
					$error("result transfer with nothing expected: server %0d", out_data.server);
					fail_count++;
				end else begin
					want = assign_q.pop_front();
					check_field("server", want.server, out_data.server);
					check_field("start_time", want.start_time, out_data.start_time);
					check_field("finish_time", want.finish_time, out_data.finish_time);
					check_field("next_server", want.next_server, out_data.next_server);
				end
			end
			if (in_valid && !in_stall)
				assign_q.push_back(next_assignment(in_data));
			pending <= assign_q.size();
		end
	end

endmodule

@@ dv/tb_earliest_free_server_assign_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the earliest-free-server assignment unit: clock, reset, job and
// server count stimulus with random idling, watchdog and verdict. Depends on efsa_pkg,
// efsa_checker and the unit itself.

module tb_earliest_free_server_assign_unit;
	import efsa_pkg::*;

	localparam int WATCHDOG_LIMIT = 4096;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_PHASES  = 25;
	localparam int PHASE_JOBS     = 70;
	localparam int LONG_JOBS      = 20;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	efsa_in_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	efsa_out_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	int unsigned fail_count;
	int unsigned results_open;
	int unsigned gap_pct    = 0;
	int unsigned stall_pct  = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;

	earliest_free_server_assign_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	efsa_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (results_open)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: stall in bursts of random length while idling is enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(1, 12) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too many cycles without any transfer means the unit is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one job, possibly after an idle burst, and returns once it is transferred.
	task automatic send_job(input logic [SVC_W-1:0] svc, input logic first);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{service_time: svc, first_of_case: first};
		do @(posedge clk); while (in_stall);
	endtask

	// Writes the server count once every outstanding result has come back.
	task automatic write_count(input logic [CFG_W-1:0] count);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_open != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly short service times so that servers tie often, with extremes mixed in.
	function automatic logic [SVC_W-1:0] random_service_time();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return SVC_W'($urandom);
			default: return SVC_W'($urandom_range(0, 200));
		endcase
	endfunction

	initial begin
		int               p;
		int               i;
		logic [CFG_W-1:0] count;
		logic             fresh;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One server after reset, then a clear in the middle of a case.
		send_job(16'd0, 1'b0);
		send_job(16'hFFFF, 1'b0);
		send_job(16'd1, 1'b1);

		// Four servers: fill in order, then earliest free and ties to the lowest index.
		write_count(7'd4);
		send_job(16'd10, 1'b1);
		send_job(16'd0, 1'b0);
		send_job(16'd10, 1'b0);
		send_job(16'd3, 1'b0);
		send_job(16'd7, 1'b0);
		send_job(16'd7, 1'b0);
		send_job(16'd3, 1'b0);
		send_job(16'd0, 1'b0);

		// Count lowered mid-case: only the first two servers are searched.
		write_count(7'd2);
		send_job(16'd1, 1'b0);
		send_job(16'd1, 1'b0);

		// Count raised mid-case: the new servers are used first, from time zero.
		write_count(7'd6);
		send_job(16'd5, 1'b0);
		send_job(16'd5, 1'b0);
		send_job(16'd5, 1'b0);

		// Out-of-range counts: zero acts as one, above the table acts as the full table.
		write_count(7'd0);
		send_job(16'd2, 1'b1);
		send_job(16'd2, 1'b0);
		write_count(7'd127);
		send_job(16'd4, 1'b1);
		send_job(16'd4, 1'b0);

		// Random phases, each with its own count and idling profile; the last one runs
		// at full rate.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 8)
				0: count = 7'd1;
				1: count = 7'd64;
				2: count = 7'd0;
				3: count = 7'd127;
				4: count = 7'd65;
				default: count = ($urandom_range(0, 3) == 0) ?
						CFG_W'($urandom_range(9, 63)) : CFG_W'($urandom_range(2, 8));
			endcase
			if ((p % 3 == 2) || (p == RANDOM_PHASES - 1)) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			write_count(count);
			// Most phases open a new case; the rest carry the table over.
			fresh = ($urandom_range(0, 3) != 0);
			for (i = 0; i < PHASE_JOBS; i++)
				send_job(random_service_time(),
						(i == 0) ? fresh : ($urandom_range(0, 49) == 0));
		end

		// Long service times piling up on a single server, run at full rate with no idling.
		gap_pct = 0;
		stall_pct = 0;
		write_count(7'd1);
		send_job(16'hFFFF, 1'b1);
		repeat (LONG_JOBS) send_job(16'hFFFF, 1'b0);
		send_job(16'd0, 1'b0);
		send_job(16'd1, 1'b0);
		write_count(7'd2);
		send_job(16'hFFFF, 1'b0);
		send_job(16'd1, 1'b0);

		// Drain and give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_open != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
